// File: rtl/wvw_pkg.sv
// ----------------------------------------------------------------------------
// wvw_pkg
// Shared sizes, opcodes and control structs of the weighted voronoi water
// counter.
// ----------------------------------------------------------------------------
package wvw_pkg;

    localparam int MAX_ATOMS  = 256;
    localparam int MAX_WATERS = 1024;

    localparam int ATOM_AW  = $clog2(MAX_ATOMS);
    localparam int WATER_AW = $clog2(MAX_WATERS);
    localparam int ATOM_CW  = $clog2(MAX_ATOMS + 1);
    localparam int WATER_CW = $clog2(MAX_WATERS + 1);

    localparam int POS_W    = 24;
    localparam int RAD_W    = 16;
    localparam int CNT_W    = 19;
    localparam int ATOM_DW  = 3 * POS_W + RAD_W;
    localparam int WATER_DW = 3 * POS_W;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] OP_LOAD_ATOM  = 2'd0;
    localparam logic [1:0] OP_LOAD_WATER = 2'd1;
    localparam logic [1:0] OP_COMPUTE    = 2'd2;

    localparam int          APB_AW      = 3;
    localparam logic        REG_PROBE   = 1'b0;
    localparam logic [15:0] PROBE_RESET = 16'd358;

    typedef struct packed {
        logic                start;
        logic [ATOM_CW-1:0]  na;
        logic [WATER_CW-1:0] nw;
        logic [RAD_W-1:0]    probe;
    } t_seq_cfg;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] count;
    } t_seq_stat;

endpackage

// File: rtl/wvw_if.sv
// ----------------------------------------------------------------------------
// wvw_in_if / wvw_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface wvw_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [15:0]        atom_radius;

    modport source(output valid, opcode, pos_x, pos_y, pos_z, atom_radius, input ready);
    modport sink(input valid, opcode, pos_x, pos_y, pos_z, atom_radius, output ready);
endinterface

interface wvw_out_if;
    logic        valid;
    logic        ready;
    logic [18:0] water_count;
    logic        load_dropped;

    modport source(output valid, water_count, load_dropped, input ready);
    modport sink(input valid, water_count, load_dropped, output ready);
endinterface

// File: rtl/wvw_ram.sv
// ----------------------------------------------------------------------------
// wvw_ram
// Generic simple dual port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wvw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/wvw_mul.sv
// ----------------------------------------------------------------------------
// wvw_mul
// Shared 32 x 32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module wvw_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'b0, i_a} * {32'b0, i_b};
    end

    assign o_p = r_p;

endmodule

// File: rtl/wvw_seq.sv
// ----------------------------------------------------------------------------
// wvw_seq
// Pair counting sequencer: walks atoms, neighbors and waters and drives
// the shared multiplier, which can take a new operand pair while the previous product is read back.
// ----------------------------------------------------------------------------
module wvw_seq import wvw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_seq_cfg            i_cfg,
    input  logic                i_out_free,
    input  logic [ATOM_DW-1:0]  i_atom_rdata,
    input  logic [WATER_DW-1:0] i_water_rdata,
    output logic [ATOM_AW-1:0]  o_atom_raddr,
    output logic [WATER_AW-1:0] o_water_raddr,
    output t_seq_stat           o_stat
);

    localparam int ST_W   = 5;
    localparam int ACC_W  = 82;
    localparam int DIST_W = 50;
    localparam int WL_W   = 34;

    localparam logic [ST_W-1:0] S_IDLE   = 5'd0;
    localparam logic [ST_W-1:0] S_AI_RD  = 5'd1;
    localparam logic [ST_W-1:0] S_AI_CAP = 5'd2;
    localparam logic [ST_W-1:0] S_NB_RD  = 5'd3;
    localparam logic [ST_W-1:0] S_NB_CAP = 5'd4;
    localparam logic [ST_W-1:0] S_NB_L0  = 5'd5;
    localparam logic [ST_W-1:0] S_NB_L1  = 5'd6;
    localparam logic [ST_W-1:0] S_WL0    = 5'd7;
    localparam logic [ST_W-1:0] S_WL1    = 5'd8;
    localparam logic [ST_W-1:0] S_WL2    = 5'd9;
    localparam logic [ST_W-1:0] S_W_RD   = 5'd10;
    localparam logic [ST_W-1:0] S_W_CAP  = 5'd11;
    localparam logic [ST_W-1:0] S_W_CHK  = 5'd12;
    localparam logic [ST_W-1:0] S_J_RD   = 5'd13;
    localparam logic [ST_W-1:0] S_J_CAP  = 5'd14;
    localparam logic [ST_W-1:0] S_J_P0   = 5'd15;
    localparam logic [ST_W-1:0] S_J_P1   = 5'd16;
    localparam logic [ST_W-1:0] S_J_P2   = 5'd17;
    localparam logic [ST_W-1:0] S_J_P3   = 5'd18;
    localparam logic [ST_W-1:0] S_J_P4   = 5'd19;
    localparam logic [ST_W-1:0] S_J_P5   = 5'd20;
    localparam logic [ST_W-1:0] S_J_P6   = 5'd21;
    localparam logic [ST_W-1:0] S_D0     = 5'd22;
    localparam logic [ST_W-1:0] S_D1     = 5'd23;
    localparam logic [ST_W-1:0] S_D2     = 5'd24;
    localparam logic [ST_W-1:0] S_D3     = 5'd25;
    localparam logic [ST_W-1:0] S_DONE   = 5'd26;

    localparam logic [1:0] SEL_IJ = 2'd0;
    localparam logic [1:0] SEL_IW = 2'd1;
    localparam logic [1:0] SEL_WJ = 2'd2;

    logic [ST_W-1:0]     r_state, n_state;
    logic [ST_W-1:0]     r_ret, n_ret;
    logic [1:0]          r_sel, n_sel;
    logic [ATOM_CW-1:0]  r_na, n_na;
    logic [WATER_CW-1:0] r_nw, n_nw;
    logic [RAD_W-1:0]    r_probe, n_probe;
    logic [ATOM_CW-1:0]  r_i, n_i;
    logic [ATOM_CW-1:0]  r_j, n_j;
    logic [WATER_CW-1:0] r_w, n_w;
    logic                r_any, n_any;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [POS_W-1:0]    r_ix, r_iy, r_iz, n_ix, n_iy, n_iz;
    logic [RAD_W-1:0]    r_ir, n_ir;
    logic [POS_W-1:0]    r_jx, r_jy, r_jz, n_jx, n_jy, n_jz;
    logic [RAD_W-1:0]    r_jr, n_jr;
    logic [POS_W-1:0]    r_wx, r_wy, r_wz, n_wx, n_wy, n_wz;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [ACC_W-1:0]    r_left, n_left;
    logic [WL_W-1:0]     r_wl, n_wl;
    logic [31:0]         r_ri2, n_ri2;
    logic [31:0]         r_rj2, n_rj2;
    logic [DIST_W-1:0]   r_diw, n_diw;
    logic [DIST_W-1:0]   r_dwj, n_dwj;

    logic        flag_we;
    logic        flag_wd;
    logic        flag_rd;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [ACC_W-1:0] prod_ext;
    logic [ACC_W-1:0] prod_hi;

    logic [POS_W-1:0]   px, py, pz, qx, qy, qz;
    logic signed [24:0] dx, dy, dz;
    logic [24:0]        adx, ady, adz;
    logic [17:0]        lim;
    logic [16:0]        wr;

    wvw_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // neighbor flags of the current atom, read through a registered read port
    wvw_ram #(.WIDTH(1), .DEPTH(MAX_ATOMS)) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (r_j[ATOM_AW-1:0]),
        .i_wdata (flag_wd),
        .i_raddr (r_j[ATOM_AW-1:0]),
        .o_rdata (flag_rd)
    );

    assign prod_ext = {{(ACC_W - 64){1'b0}}, prod};
    assign prod_hi  = prod_ext << 25;

    // distance operand select
    always_comb begin
        case (r_sel)
            SEL_IJ: begin
                px = r_ix; py = r_iy; pz = r_iz; qx = r_jx; qy = r_jy; qz = r_jz;
            end
            SEL_IW: begin
                px = r_ix; py = r_iy; pz = r_iz; qx = r_wx; qy = r_wy; qz = r_wz;
            end
            default: begin
                px = r_wx; py = r_wy; pz = r_wz; qx = r_jx; qy = r_jy; qz = r_jz;
            end
        endcase
    end

    assign dx  = $signed({px[POS_W-1], px}) - $signed({qx[POS_W-1], qx});
    assign dy  = $signed({py[POS_W-1], py}) - $signed({qy[POS_W-1], qy});
    assign dz  = $signed({pz[POS_W-1], pz}) - $signed({qz[POS_W-1], qz});
    assign adx = dx[24] ? 25'(-dx) : 25'(dx);
    assign ady = dy[24] ? 25'(-dy) : 25'(dy);
    assign adz = dz[24] ? 25'(-dz) : 25'(dz);

    assign lim = {2'b0, r_ir} + {1'b0, r_probe, 1'b0} + {2'b0, r_jr};
    assign wr  = {1'b0, r_ir} + {1'b0, r_probe};

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_sel = r_sel;
        n_na = r_na; n_nw = r_nw; n_probe = r_probe;
        n_i = r_i; n_j = r_j; n_w = r_w; n_any = r_any; n_count = r_count;
        n_ix = r_ix; n_iy = r_iy; n_iz = r_iz; n_ir = r_ir;
        n_jx = r_jx; n_jy = r_jy; n_jz = r_jz; n_jr = r_jr;
        n_wx = r_wx; n_wy = r_wy; n_wz = r_wz;
        n_acc = r_acc; n_left = r_left; n_wl = r_wl;
        n_ri2 = r_ri2; n_rj2 = r_rj2; n_diw = r_diw; n_dwj = r_dwj;
        flag_we = 1'b0;
        flag_wd = 1'b0;
        mul_a = 32'b0;
        mul_b = 32'b0;
        o_atom_raddr  = r_j[ATOM_AW-1:0];
        o_water_raddr = r_w[WATER_AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_cfg.start) begin
                    n_na = i_cfg.na;
                    n_nw = i_cfg.nw;
                    n_probe = i_cfg.probe;
                    n_i = '0;
                    n_count = '0;
                    n_state = S_AI_RD;
                end
            end
            S_AI_RD: begin
                o_atom_raddr = r_i[ATOM_AW-1:0];
                n_state = (r_i == r_na) ? S_DONE : S_AI_CAP;
            end
            S_AI_CAP: begin
                {n_ix, n_iy, n_iz, n_ir} = i_atom_rdata;
                n_j = '0;
                n_any = 1'b0;
                n_state = S_NB_RD;
            end
            S_NB_RD: begin
                if (r_j == r_na) begin
                    if (r_any) begin
                        n_state = S_WL0;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_AI_RD;
                    end
                end else if (r_j == r_i) begin
                    flag_we = 1'b1;
                    n_j = r_j + 1'b1;
                end else begin
                    n_state = S_NB_CAP;
                end
            end
            S_NB_CAP: begin
                {n_jx, n_jy, n_jz, n_jr} = i_atom_rdata;
                n_sel = SEL_IJ;
                n_ret = S_NB_L0;
                n_state = S_D0;
            end
            S_NB_L0: begin
                mul_a = {14'b0, lim};
                mul_b = {14'b0, lim};
                n_state = S_NB_L1;
            end
            S_NB_L1: begin
                flag_we = 1'b1;
                flag_wd = (r_acc <= prod_ext);
                n_any = r_any | flag_wd;
                n_j = r_j + 1'b1;
                n_state = S_NB_RD;
            end
            S_WL0: begin
                mul_a = {15'b0, wr};
                mul_b = {15'b0, wr};
                n_state = S_WL1;
            end
            S_WL1: begin
                n_wl = prod[WL_W-1:0];
                mul_a = {16'b0, r_ir};
                mul_b = {16'b0, r_ir};
                n_state = S_WL2;
            end
            S_WL2: begin
                n_ri2 = prod[31:0];
                n_w = '0;
                n_state = S_W_RD;
            end
            S_W_RD: begin
                if (r_w == r_nw) begin
                    n_i = r_i + 1'b1;
                    n_state = S_AI_RD;
                end else begin
                    n_state = S_W_CAP;
                end
            end
            S_W_CAP: begin
                {n_wx, n_wy, n_wz} = i_water_rdata;
                n_sel = SEL_IW;
                n_ret = S_W_CHK;
                n_state = S_D0;
            end
            S_W_CHK: begin
                if (r_acc < {{(ACC_W - WL_W){1'b0}}, r_wl}) begin
                    n_diw = r_acc[DIST_W-1:0];
                    n_j = '0;
                    n_state = S_J_RD;
                end else begin
                    n_w = r_w + 1'b1;
                    n_state = S_W_RD;
                end
            end
            S_J_RD: begin
                if (r_j == r_na) begin
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                    n_w = r_w + 1'b1;
                    n_state = S_W_RD;
                end else begin
                    n_state = S_J_CAP;
                end
            end
            S_J_CAP: begin
                // flag and atom data of entry j arrive together
                if (!flag_rd) begin
                    n_j = r_j + 1'b1;
                    n_state = S_J_RD;
                end else begin
                    {n_jx, n_jy, n_jz, n_jr} = i_atom_rdata;
                    n_sel = SEL_WJ;
                    n_ret = S_J_P0;
                    n_state = S_D0;
                end
            end
            S_J_P0: begin
                n_dwj = r_acc[DIST_W-1:0];
                mul_a = {16'b0, r_jr};
                mul_b = {16'b0, r_jr};
                n_state = S_J_P1;
            end
            S_J_P1: begin
                n_rj2 = prod[31:0];
                mul_a = {7'b0, r_diw[24:0]};
                mul_b = prod[31:0];
                n_state = S_J_P2;
            end
            S_J_P2: begin
                n_acc = prod_ext;
                mul_a = {7'b0, r_diw[49:25]};
                mul_b = r_rj2;
                n_state = S_J_P3;
            end
            S_J_P3: begin
                // left side: diw * rj^2
                n_left = r_acc + prod_hi;
                mul_a = {7'b0, r_dwj[24:0]};
                mul_b = r_ri2;
                n_state = S_J_P4;
            end
            S_J_P4: begin
                n_acc = prod_ext;
                mul_a = {7'b0, r_dwj[49:25]};
                mul_b = r_ri2;
                n_state = S_J_P5;
            end
            S_J_P5: begin
                n_acc = r_acc + prod_hi;
                n_state = S_J_P6;
            end
            S_J_P6: begin
                if (r_left < r_acc) begin
                    n_j = r_j + 1'b1;
                    n_state = S_J_RD;
                end else begin
                    n_w = r_w + 1'b1;
                    n_state = S_W_RD;
                end
            end
            S_D0: begin
                mul_a = {7'b0, adx};
                mul_b = {7'b0, adx};
                n_state = S_D1;
            end
            S_D1: begin
                n_acc = prod_ext;
                mul_a = {7'b0, ady};
                mul_b = {7'b0, ady};
                n_state = S_D2;
            end
            S_D2: begin
                n_acc = r_acc + prod_ext;
                mul_a = {7'b0, adz};
                mul_b = {7'b0, adz};
                n_state = S_D3;
            end
            S_D3: begin
                n_acc = r_acc + prod_ext;
                n_state = r_ret;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret; r_sel <= n_sel;
        r_na <= n_na; r_nw <= n_nw; r_probe <= n_probe;
        r_i <= n_i; r_j <= n_j; r_w <= n_w; r_any <= n_any; r_count <= n_count;
        r_ix <= n_ix; r_iy <= n_iy; r_iz <= n_iz; r_ir <= n_ir;
        r_jx <= n_jx; r_jy <= n_jy; r_jz <= n_jz; r_jr <= n_jr;
        r_wx <= n_wx; r_wy <= n_wy; r_wz <= n_wz;
        r_acc <= n_acc; r_left <= n_left; r_wl <= n_wl;
        r_ri2 <= n_ri2; r_rj2 <= n_rj2; r_diw <= n_diw; r_dwj <= n_dwj;
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.done  = (r_state == S_DONE) && i_out_free;
    assign o_stat.count = r_count;

    // neighbor fetches only ever target loaded entries, never the atom itself
    a_nb_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NB_CAP) |-> (r_j < r_na) && (r_j != r_i))
        else $error("neighbor fetch out of range");

    a_water_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W_CAP) |-> (r_w < r_nw))
        else $error("water fetch out of range");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.start |-> (r_state == S_IDLE))
        else $error("compute started while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle");

endmodule

// File: rtl/weighted_voronoi_water_counter_top.sv
// ----------------------------------------------------------------------------
// weighted_voronoi_water_counter_top
// Atom and water stores, load counters, probe radius register and result
// register around the pair counting sequencer.
//
//   channel   dir   handshake              payload
//   in_ch     in    valid/ready            opcode, pos_x/y/z, atom_radius
//   out_ch    out   valid/ready            water_count, load_dropped
//   apb       in    psel/penable/pwrite    paddr, pwdata, prdata (probe_radius)
//
// loads can arrive back to back while no compute runs
// a compute transaction scans every ordered atom pair, then for each atom
// with a neighbor walks all waters, and for each water inside its shell
// checks the neighbors in turn; the single shared 32x32 multiplier gives one
// product a cycle
// in_ch is not ready while a compute runs; a finished count waits in the
// result register until out_ch takes it
// synchronous active-low reset clears counters, the overflow flag and the result valid
// ----------------------------------------------------------------------------
module weighted_voronoi_water_counter_top import wvw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wvw_in_if.sink            in_ch,
    wvw_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [RAD_W-1:0]    r_probe;
    logic [ATOM_CW-1:0]  r_na;
    logic [WATER_CW-1:0] r_nw;
    logic                r_ovf;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_out_count;
    logic                r_out_drop;

    logic                accept;
    logic                atom_we, water_we;
    logic                atom_full, water_full;
    logic                out_free;
    logic [ATOM_AW-1:0]  atom_raddr;
    logic [WATER_AW-1:0] water_raddr;
    logic [ATOM_DW-1:0]  atom_rdata;
    logic [WATER_DW-1:0] water_rdata;
    t_seq_cfg            seq_cfg;
    t_seq_stat           seq_stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROBE) ? {16'b0, r_probe} : 32'b0;

    assign in_ch.ready = !seq_stat.busy;
    assign accept      = in_ch.valid && in_ch.ready;
    assign atom_full   = (r_na == ATOM_CW'(MAX_ATOMS));
    assign water_full  = (r_nw == WATER_CW'(MAX_WATERS));
    assign atom_we     = accept && (in_ch.opcode == OP_LOAD_ATOM) && !atom_full;
    assign water_we    = accept && (in_ch.opcode == OP_LOAD_WATER) && !water_full;
    assign out_free    = !r_out_valid || out_ch.ready;

    assign seq_cfg.start = accept && (in_ch.opcode == OP_COMPUTE);
    assign seq_cfg.na    = r_na;
    assign seq_cfg.nw    = r_nw;
    assign seq_cfg.probe = r_probe;

    wvw_ram #(.WIDTH(ATOM_DW), .DEPTH(MAX_ATOMS)) u_atom_ram (
        .i_clk   (i_clk),
        .i_we    (atom_we),
        .i_waddr (r_na[ATOM_AW-1:0]),
        .i_wdata ({in_ch.pos_x, in_ch.pos_y, in_ch.pos_z, in_ch.atom_radius}),
        .i_raddr (atom_raddr),
        .o_rdata (atom_rdata)
    );

    wvw_ram #(.WIDTH(WATER_DW), .DEPTH(MAX_WATERS)) u_water_ram (
        .i_clk   (i_clk),
        .i_we    (water_we),
        .i_waddr (r_nw[WATER_AW-1:0]),
        .i_wdata ({in_ch.pos_x, in_ch.pos_y, in_ch.pos_z}),
        .i_raddr (water_raddr),
        .o_rdata (water_rdata)
    );

    wvw_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (seq_cfg),
        .i_out_free    (out_free),
        .i_atom_rdata  (atom_rdata),
        .i_water_rdata (water_rdata),
        .o_atom_raddr  (atom_raddr),
        .o_water_raddr (water_raddr),
        .o_stat        (seq_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe     <= PROBE_RESET;
            r_na        <= '0;
            r_nw        <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && (paddr[2] == REG_PROBE)) begin
                r_probe <= pwdata[RAD_W-1:0];
            end
            if (atom_we) begin
                r_na <= r_na + 1'b1;
            end
            if (water_we) begin
                r_nw <= r_nw + 1'b1;
            end
            if (accept && (in_ch.opcode == OP_LOAD_ATOM) && atom_full) begin
                r_ovf <= 1'b1;
            end
            if (accept && (in_ch.opcode == OP_LOAD_WATER) && water_full) begin
                r_ovf <= 1'b1;
            end
            // compute finished: hand over the count and clear both stores
            if (seq_stat.done) begin
                r_out_valid <= 1'b1;
                r_na        <= '0;
                r_nw        <= '0;
                r_ovf       <= 1'b0;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.done) begin
            r_out_count <= seq_stat.count;
            r_out_drop  <= r_ovf;
        end
    end

    assign out_ch.valid        = r_out_valid;
    assign out_ch.water_count  = r_out_count;
    assign out_ch.load_dropped = r_out_drop;

endmodule

// File: tb/sv/tb_weighted_voronoi_water_counter_top.sv
// ----------------------------------------------------------------------------
// tb_weighted_voronoi_water_counter_top
// Self-checking bench for the weighted voronoi water counter. It loads
// clustered atoms and waters with random content, mixed with noise items,
// issues compute transactions, and checks every count against a predictor
// kept in a small scoreboard class. The bench steps the probe radius through
// several values and varies sender and receiver idling between phases. The
// atom store is also driven past capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_weighted_voronoi_water_counter_top;
    import wvw_pkg::*;

    localparam longint     CYCLE_LIMIT = 6_000_000;
    localparam int         PHASE_ITEMS = 200;
    localparam logic [1:0] OP_SPARE    = 2'd3;

    // pair counter and expected result store
    class wvw_scoreboard;
        int            atom_px[MAX_ATOMS], atom_py[MAX_ATOMS], atom_pz[MAX_ATOMS];
        int unsigned   atom_rad[MAX_ATOMS];
        int            water_px[MAX_WATERS], water_py[MAX_WATERS], water_pz[MAX_WATERS];
        int            atom_cnt, water_cnt;
        bit            overflow;
        bit [15:0]     probe;
        bit            is_nbr[MAX_ATOMS];
        bit [CNT_W-1:0] count_q[$];
        bit            dropped_q[$];
        int            errors;

        function new();
            atom_cnt = 0;
            water_cnt = 0;
            overflow = 0;
            probe = PROBE_RESET;
            errors = 0;
        endfunction

        function longint unsigned sq_dist(int ax, int ay, int az, int bx, int by, int bz);
            longint dx, dy, dz;
            dx = longint'(ax) - bx;
            dy = longint'(ay) - by;
            dz = longint'(az) - bz;
            return dx * dx + dy * dy + dz * dz;
        endfunction

        function int unsigned count_pairs();
            int unsigned total;
            longint unsigned r, ri, rj, lim, wl, diw, dwj;
            bit any_nbr, ok;
            logic [127:0] lhs, rhs;
            total = 0;
            r = probe;
            for (int i = 0; i < atom_cnt; i++) begin
                ri = atom_rad[i];
                any_nbr = 0;
                for (int j = 0; j < atom_cnt; j++) begin
                    is_nbr[j] = 0;
                    if (j != i) begin
                        lim = ri + 2 * r + atom_rad[j];
                        if (sq_dist(atom_px[i], atom_py[i], atom_pz[i],
                                    atom_px[j], atom_py[j], atom_pz[j]) <= lim * lim) begin
                            is_nbr[j] = 1;
                            any_nbr = 1;
                        end
                    end
                end
                if (!any_nbr) continue;
                wl = (ri + r) * (ri + r);
                for (int w = 0; w < water_cnt; w++) begin
                    diw = sq_dist(atom_px[i], atom_py[i], atom_pz[i],
                                  water_px[w], water_py[w], water_pz[w]);
                    if (diw >= wl) continue;
                    ok = 1;
                    for (int j = 0; j < atom_cnt && ok; j++) begin
                        if (is_nbr[j]) begin
                            rj = atom_rad[j];
                            dwj = sq_dist(water_px[w], water_py[w], water_pz[w],
                                          atom_px[j], atom_py[j], atom_pz[j]);
                            lhs = 128'(diw) * 128'(rj * rj);
                            rhs = 128'(dwj) * 128'(ri * ri);
                            if (!(lhs < rhs)) ok = 0;
                        end
                    end
                    if (ok && total < COUNT_MAX) total++;
                end
            end
            return total;
        endfunction

        function void note_input(logic [1:0] op, logic signed [23:0] x,
                                 logic signed [23:0] y, logic signed [23:0] z,
                                 logic [15:0] rad);
            case (op)
                OP_LOAD_ATOM: begin
                    if (atom_cnt < MAX_ATOMS) begin
                        atom_px[atom_cnt] = x;
                        atom_py[atom_cnt] = y;
                        atom_pz[atom_cnt] = z;
                        atom_rad[atom_cnt] = rad;
                        atom_cnt++;
                    end else begin
                        overflow = 1;
                    end
                end
                OP_LOAD_WATER: begin
                    if (water_cnt < MAX_WATERS) begin
                        water_px[water_cnt] = x;
                        water_py[water_cnt] = y;
                        water_pz[water_cnt] = z;
                        water_cnt++;
                    end else begin
                        overflow = 1;
                    end
                end
                OP_COMPUTE: begin
                    count_q = {count_q, CNT_W'(count_pairs())};
                    dropped_q = {dropped_q, overflow};
                    atom_cnt = 0;
                    water_cnt = 0;
                    overflow = 0;
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [CNT_W-1:0] cnt, logic drp);
            bit [CNT_W-1:0] exp_cnt;
            bit exp_drp;
            if (count_q.size() == 0) begin
                report($sformatf("unexpected result count=%0d dropped=%0b", cnt, drp));
            end else begin
                exp_cnt = count_q.pop_front();
                exp_drp = dropped_q.pop_front();
                if (cnt !== exp_cnt)
                    report($sformatf("water_count got %0d want %0d", cnt, exp_cnt));
                if (drp !== exp_drp)
                    report($sformatf("load_dropped got %0b want %0b", drp, exp_drp));
            end
        endtask

        function int pending();
            return count_q.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    wvw_in_if  in_ch();
    wvw_out_if out_ch();

    weighted_voronoi_water_counter_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wvw_scoreboard sb = new();
    int     idle_pct;
    int     stall_pct;
    longint cycles;
    int     sent;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: check each transaction, then pick the next ready level
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.water_count, out_ch.load_dropped);
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task send_item(logic [1:0] op, logic signed [23:0] x, logic signed [23:0] y,
                   logic signed [23:0] z, logic [15:0] rad);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.pos_x       <= x;
        in_ch.pos_y       <= y;
        in_ch.pos_z       <= z;
        in_ch.atom_radius <= rad;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_input(op, x, y, z, rad);
        sent++;
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task write_probe(logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * int'(REG_PROBE));
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.probe = value;
    endtask

    function logic signed [23:0] near(logic signed [23:0] c, int spread);
        return c + 24'(int'($urandom_range(2 * spread)) - spread);
    endfunction

    // one cluster of atoms and waters, some noise, then a compute
    task cluster_burst();
        logic signed [23:0] cx, cy, cz;
        logic [15:0] rad;
        int na, nw, spread;
        cx = 24'($urandom);
        cy = 24'($urandom);
        cz = 24'($urandom);
        na = $urandom_range(6);
        nw = $urandom_range(12);
        spread = ($urandom_range(3) == 0) ? 3000 : 900;
        while (na + nw > 0) begin
            if ($urandom_range(9) == 0) begin
                send_item(2'($urandom_range(3)), 24'($urandom), 24'($urandom),
                          24'($urandom), 16'($urandom));
            end else if (na > 0 && (nw == 0 || $urandom_range(1))) begin
                case ($urandom_range(9))
                    0: rad = 16'd0;
                    1: rad = 16'($urandom);
                    default: rad = 16'($urandom_range(600, 200));
                endcase
                send_item(OP_LOAD_ATOM, near(cx, spread), near(cy, spread),
                          near(cz, spread), rad);
                na--;
            end else begin
                send_item(OP_LOAD_WATER, near(cx, spread + 300), near(cy, spread + 300),
                          near(cz, spread + 300), 16'($urandom));
                nw--;
            end
        end
        send_item(OP_COMPUTE, 24'($urandom), 24'($urandom), 24'($urandom),
                  16'($urandom));
    endtask

    initial begin
        int base;
        logic signed [23:0] cx;
        cycles        = 0;
        sent          = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.opcode  = OP_LOAD_ATOM;
        in_ch.pos_x   = '0;
        in_ch.pos_y   = '0;
        in_ch.pos_z   = '0;
        in_ch.atom_radius = '0;
        out_ch.ready  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes, the unused opcode, zero radius and a lone atom
        send_item(OP_LOAD_ATOM, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF);
        send_item(OP_LOAD_ATOM, 24'sh800000, 24'sh800000, 24'sh800000, 16'h0000);
        send_item(OP_LOAD_WATER, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF);
        send_item(OP_LOAD_WATER, 24'sh800000, 24'sh800000, 24'sh800000, 16'h0000);
        send_item(OP_SPARE, 24'shFFFFFF, 24'shFFFFFF, 24'shFFFFFF, 16'hFFFF);
        send_item(OP_COMPUTE, '0, '0, '0, '0);
        send_item(OP_LOAD_ATOM, 24'sd0, 24'sd0, 24'sd0, 16'd400);
        send_item(OP_LOAD_ATOM, 24'sd600, 24'sd0, 24'sd0, 16'd0);
        send_item(OP_LOAD_ATOM, 24'sh800000, 24'sd0, 24'sd0, 16'd300);
        send_item(OP_LOAD_WATER, 24'sd100, 24'sd0, 24'sd0, '0);
        send_item(OP_LOAD_WATER, -24'sd200, 24'sd50, 24'sd0, '0);
        send_item(OP_LOAD_WATER, 24'sd0, 24'sd0, 24'sd0, '0);
        send_item(OP_COMPUTE, '0, '0, '0, '0);
        send_item(OP_COMPUTE, '0, '0, '0, '0);
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 83; stall_pct = 0;  write_probe(16'd0); end
                2: begin idle_pct = 0;  stall_pct = 83; write_probe(16'hFFFF); end
                default: begin
                    idle_pct = 28; stall_pct = 28; write_probe(16'($urandom));
                end
            endcase
            base = sent;
            while (sent - base < PHASE_ITEMS) cluster_burst();

            // close atom pair inside a water cloud
            if (p == 0) begin
                cx = 24'($urandom);
                send_item(OP_LOAD_ATOM, cx, 24'sd0, 24'sd0, 16'd400);
                send_item(OP_LOAD_ATOM, cx + 24'sd700, 24'sd0, 24'sd0, 16'd350);
                for (int w = 0; w < 60; w++)
                    send_item(OP_LOAD_WATER, near(cx, 1200), near(24'sd0, 900),
                              near(24'sd0, 900), 16'($urandom));
                send_item(OP_COMPUTE, '0, '0, '0, '0);
            end
            // atom store past capacity, no waters
            if (p == 2) begin
                for (int a = 0; a <= MAX_ATOMS; a++)
                    send_item(OP_LOAD_ATOM, 24'($urandom), 24'($urandom), 24'($urandom),
                              16'($urandom));
                send_item(OP_COMPUTE, '0, '0, '0, '0);
            end
            drain();
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
